>>> hw/rtl/sst_pkg.sv
package sst_pkg;

	localparam int VALUE_WIDTH     = 32;
	localparam int COUNT_WIDTH     = 16;
	localparam int THR_WIDTH       = VALUE_WIDTH + 2;
	localparam int DIFF_WIDTH      = 34;
	localparam int SUM_WIDTH       = 32;
	localparam int NUM_WIDTH       = 33;
	localparam int DEN_WIDTH       = 34;
	localparam int CFG_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 1;

	// register indexes of the config port
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXTRA_POS = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXTRA_NEG = 1'b1;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic [COUNT_WIDTH-1:0]        pos_count;
		logic [COUNT_WIDTH-1:0]        neg_count;
		logic                          last_item;
	} sst_item_t;

	typedef struct packed {
		logic signed [THR_WIDTH-1:0] threshold_x2;
		logic [NUM_WIDTH-1:0]        error_numerator;
		logic [DEN_WIDTH-1:0]        error_denominator;
	} sst_result_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] extra_pos;
		logic [CFG_WIDTH-1:0] extra_neg;
	} sst_cfg_t;

endpackage

>>> hw/rtl/sst_item_if.sv
interface sst_item_if
	import sst_pkg::*;
();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] sample_value;
	logic [COUNT_WIDTH-1:0]        pos_count;
	logic [COUNT_WIDTH-1:0]        neg_count;
	logic                          last_item;

	modport source (output valid, sample_value, pos_count, neg_count, last_item, input ready);
	modport sink (input valid, sample_value, pos_count, neg_count, last_item, output ready);
endinterface

>>> hw/rtl/sst_result_if.sv
interface sst_result_if
	import sst_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic signed [THR_WIDTH-1:0] threshold_x2;
	logic [NUM_WIDTH-1:0]        error_numerator;
	logic [DEN_WIDTH-1:0]        error_denominator;

	modport source (output valid, threshold_x2, error_numerator, error_denominator,
		input ready);
	modport sink (input valid, threshold_x2, error_numerator, error_denominator,
		output ready);
endinterface

>>> hw/rtl/sst_cfg_regs.sv
module sst_cfg_regs
	import sst_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data,
	output sst_cfg_t                   cfg
);

	sst_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_EXTRA_POS: begin
					cfg_q.extra_pos <= cfg_data;
				end
				CFG_EXTRA_NEG: begin
					cfg_q.extra_neg <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/sst_core.sv
module sst_core
	import sst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  sst_item_t   item,
	input  sst_cfg_t    cfg,
	output sst_result_t result
);

	logic                          first_q;
	logic signed [VALUE_WIDTH-1:0] prev_q;
	logic [DIFF_WIDTH-1:0]         run_diff_q;
	logic [DIFF_WIDTH-1:0]         best_diff_q;
	logic signed [THR_WIDTH-1:0]   best_thr_q;
	logic [SUM_WIDTH-1:0]          pos_sum_q;
	logic [SUM_WIDTH-1:0]          neg_sum_q;

	logic signed [THR_WIDTH-1:0] v_ext;
	logic signed [THR_WIDTH-1:0] prev_ext;
	logic [DIFF_WIDTH-1:0]       rd;
	logic [DIFF_WIDTH-1:0]       bd;
	logic signed [THR_WIDTH-1:0] bt;
	logic [DIFF_WIDTH-1:0]       rd_n;
	logic [DIFF_WIDTH-1:0]       bd_f;
	logic signed [THR_WIDTH-1:0] bt_f;
	logic [SUM_WIDTH-1:0]        pos_sum_n;
	logic [SUM_WIDTH-1:0]        neg_sum_n;
	logic [DIFF_WIDTH-1:0]       num_full;

	assign v_ext    = {{(THR_WIDTH-VALUE_WIDTH){item.sample_value[VALUE_WIDTH-1]}},
		item.sample_value};
	assign prev_ext = {{(THR_WIDTH-VALUE_WIDTH){prev_q[VALUE_WIDTH-1]}}, prev_q};

	always_comb begin
		rd = run_diff_q;
		bd = best_diff_q;
		bt = best_thr_q;
		// lower edge on the first item, midpoint between distinct neighbors after
		if (first_q) begin
			rd = '0;
			bd = '0;
			bt = (v_ext <<< 1) - THR_WIDTH'(1);
		end else if (item.sample_value != prev_q && $signed(rd) < $signed(bd)) begin
			bd = rd;
			bt = prev_ext + v_ext;
		end
		rd_n      = rd + DIFF_WIDTH'(item.neg_count) - DIFF_WIDTH'(item.pos_count);
		pos_sum_n = pos_sum_q + SUM_WIDTH'(item.pos_count);
		neg_sum_n = neg_sum_q + SUM_WIDTH'(item.neg_count);
		// upper edge, only meaningful on the last beat
		bd_f = bd;
		bt_f = bt;
		if ($signed(rd_n) < $signed(bd)) begin
			bd_f = rd_n;
			bt_f = (v_ext <<< 1) + THR_WIDTH'(1);
		end
		num_full = DIFF_WIDTH'(pos_sum_n) + DIFF_WIDTH'(cfg.extra_neg) + bd_f;
		result.threshold_x2      = bt_f;
		result.error_numerator   = num_full[NUM_WIDTH-1:0];
		result.error_denominator = DEN_WIDTH'(pos_sum_n) + DEN_WIDTH'(neg_sum_n)
			+ DEN_WIDTH'(cfg.extra_pos) + DEN_WIDTH'(cfg.extra_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			prev_q      <= '0;
			run_diff_q  <= '0;
			best_diff_q <= '0;
			best_thr_q  <= '0;
			pos_sum_q   <= '0;
			neg_sum_q   <= '0;
		end else if (step) begin
			if (item.last_item) begin
				// rearm for the next stream
				first_q     <= 1'b1;
				prev_q      <= '0;
				run_diff_q  <= '0;
				best_diff_q <= '0;
				best_thr_q  <= '0;
				pos_sum_q   <= '0;
				neg_sum_q   <= '0;
			end else begin
				first_q     <= 1'b0;
				prev_q      <= item.sample_value;
				run_diff_q  <= rd_n;
				best_diff_q <= bd;
				best_thr_q  <= bt;
				pos_sum_q   <= pos_sum_n;
				neg_sum_q   <= neg_sum_n;
			end
		end
	end

endmodule

>>> hw/rtl/sorted_stump_threshold_search_top.sv
// channel  | dir | beat contents                                        | when
// ---------+-----+------------------------------------------------------+---------------------------
// item     | in  | sample_value, pos_count, neg_count, last_item        | one beat per sorted value
// result   | out | threshold_x2, error_numerator, error_denominator     | one beat per last_item
// cfg      | in  | cfg_write, cfg_index, cfg_data (extra_pos/extra_neg) | write only, no handshake
//
// one item per cycle sustained, except while a last item waits for a full result register to drain
// path: item register -> running sums, best split compare and result adders -> result register
// reset clears the stream state, the config registers and both valid flags
// a stalled result only holds back a last item in the item register; earlier beats keep flowing
// config writes are expected only between streams with the block drained
module sorted_stump_threshold_search_top
	import sst_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	sst_item_if.sink                   item,
	sst_result_if.source               result,
	input  logic                       cfg_write,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data
);

	sst_cfg_t    cfg;
	sst_item_t   item_s1;
	logic        valid_s1;
	sst_result_t res_next;
	sst_result_t res_q;
	logic        res_valid_q;
	logic        out_free;
	logic        step;
	logic        item_take;

	// result register is free when empty or being drained this cycle
	assign out_free  = !res_valid_q || result.ready;
	// a non-last beat never waits on the output side
	assign step      = valid_s1 && (!item_s1.last_item || out_free);
	assign item.ready = !valid_s1 || step;
	assign item_take = item.valid && item.ready;

	sst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1.sample_value <= item.sample_value;
			item_s1.pos_count    <= item.pos_count;
			item_s1.neg_count    <= item.neg_count;
			item_s1.last_item    <= item.last_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && item_s1.last_item) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_item) begin
			res_q <= res_next;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.threshold_x2      = res_q.threshold_x2;
	assign result.error_numerator   = res_q.error_numerator;
	assign result.error_denominator = res_q.error_denominator;

endmodule
